@@ hw/rtl/fifo_handle_pool_allocator_core_defines.svh @@
// ----------------------------------------------------------------------------
// handle pool allocator assertion macros
// shared concurrent assertion forms, clocked and reset-qualified
// ----------------------------------------------------------------------------
`ifndef FIFO_HANDLE_POOL_ALLOCATOR_CORE_DEFINES_SVH
`define FIFO_HANDLE_POOL_ALLOCATOR_CORE_DEFINES_SVH

// same-cycle implication
`define FHPA_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("fhpa assertion failed");

// next-cycle implication
`define FHPA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("fhpa assertion failed");

`endif

@@ hw/rtl/fhpa_pkg.sv @@
// ----------------------------------------------------------------------------
// fhpa_pkg
// types and codes shared by the handle pool allocator
// ----------------------------------------------------------------------------
package fhpa_pkg;

    localparam int HANDLE_W    = 8;
    localparam int HANDLE_SPACE = 256;
    localparam int COUNT_W     = 9;

    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_TRY   = 2'd1;
    localparam logic [1:0] OP_FREE  = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NONE    = 2'd1;
    localparam logic [1:0] ST_BADFREE = 2'd2;

    typedef struct packed {
        logic [1:0]          opcode;
        logic [HANDLE_W-1:0] handle;
    } t_req;

    typedef struct packed {
        logic [HANDLE_W-1:0] granted_handle;
        logic [1:0]          status;
    } t_rsp;

endpackage

@@ hw/rtl/fhpa_ram.sv @@
// ----------------------------------------------------------------------------
// fhpa_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module fhpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/fifo_handle_pool_allocator_core.sv @@
// ----------------------------------------------------------------------------
// fifo_handle_pool_allocator_core
// object handle pool with a fifo free queue and an in-use bitmap
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. The accept cycle
// reads the free queue head and the in-use bit of the request handle from
// their rams, the next cycle decides and writes back; the result strobe
// o_rsp_valid is high in the cycle after that, and busy is already
// low then, so a new request can be issued in that cycle. This pacing is set
// by the read-modify-write of the bitmap ram, whose read data is registered.
// The result is shown for one cycle only and must be captured then. After
// reset the block runs a clearing pass over the 256-entry bitmap with busy
// high.
// ----------------------------------------------------------------------------
`include "fifo_handle_pool_allocator_core_defines.svh"

module fifo_handle_pool_allocator_core #(
    parameter int POOL_SIZE = 256
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  fhpa_pkg::t_req i_req,
    output logic          o_rsp_valid,
    output fhpa_pkg::t_rsp o_rsp
);

    localparam int HW = fhpa_pkg::HANDLE_W;
    localparam int CW = fhpa_pkg::COUNT_W;
    localparam logic [CW-1:0] POOL_LIMIT =
        (POOL_SIZE < fhpa_pkg::HANDLE_SPACE) ? CW'(POOL_SIZE) : CW'(fhpa_pkg::HANDLE_SPACE);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_EXEC  = 2'd2;

    logic [1:0]    r_state, n_state;
    logic [HW-1:0] r_clr_idx, n_clr_idx;
    fhpa_pkg::t_req r_req;
    logic [HW-1:0] r_q_head, n_q_head;
    logic [CW-1:0] r_q_count, n_q_count;
    logic [CW-1:0] r_minted, n_minted;
    logic          r_rsp_valid, n_rsp_valid;
    fhpa_pkg::t_rsp r_rsp, n_rsp;

    logic          accept;
    logic          q_we;
    logic [HW-1:0] q_waddr;
    logic [HW-1:0] q_rdata;
    logic          m_we;
    logic [HW-1:0] m_waddr;
    logic [0:0]    m_wdata;
    logic [0:0]    m_rdata;

    assign accept = start && (r_state == S_IDLE);
    assign busy   = (r_state != S_IDLE);

    fhpa_ram #(.WIDTH(HW), .DEPTH(fhpa_pkg::HANDLE_SPACE)) u_queue_ram (
        .i_clk  (i_clk),
        .i_we   (q_we),
        .i_waddr(q_waddr),
        .i_wdata(r_req.handle),
        .i_raddr(r_q_head),
        .o_rdata(q_rdata)
    );

    fhpa_ram #(.WIDTH(1), .DEPTH(fhpa_pkg::HANDLE_SPACE)) u_map_ram (
        .i_clk  (i_clk),
        .i_we   (m_we),
        .i_waddr(m_waddr),
        .i_wdata(m_wdata),
        .i_raddr(i_req.handle),
        .o_rdata(m_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_clr_idx   = r_clr_idx;
        n_q_head    = r_q_head;
        n_q_count   = r_q_count;
        n_minted    = r_minted;
        n_rsp_valid = 1'b0;
        n_rsp       = r_rsp;
        q_we        = 1'b0;
        q_waddr     = r_q_head + r_q_count[HW-1:0];
        m_we        = 1'b0;
        m_waddr     = r_clr_idx;
        m_wdata     = 1'b0;
        case (r_state)
            S_CLEAR: begin
                m_we      = 1'b1;
                n_clr_idx = r_clr_idx + 1'b1;
                if (r_clr_idx == HW'(fhpa_pkg::HANDLE_SPACE - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state               = S_IDLE;
                n_rsp_valid           = 1'b1;
                n_rsp.granted_handle  = '0;
                n_rsp.status          = fhpa_pkg::ST_OK;
                case (r_req.opcode)
                    fhpa_pkg::OP_ALLOC, fhpa_pkg::OP_TRY: begin
                        if (r_q_count != '0) begin
                            m_we                 = 1'b1;
                            m_waddr              = q_rdata;
                            m_wdata              = 1'b1;
                            n_q_head             = r_q_head + 1'b1;
                            n_q_count            = r_q_count - 1'b1;
                            n_rsp.granted_handle = q_rdata;
                        end else if (r_req.opcode == fhpa_pkg::OP_ALLOC &&
                                     r_minted < POOL_LIMIT) begin
                            m_we                 = 1'b1;
                            m_waddr              = r_minted[HW-1:0];
                            m_wdata              = 1'b1;
                            n_minted             = r_minted + 1'b1;
                            n_rsp.granted_handle = r_minted[HW-1:0];
                        end else begin
                            n_rsp.status = fhpa_pkg::ST_NONE;
                        end
                    end
                    fhpa_pkg::OP_FREE: begin
                        if (m_rdata == 1'b0 || r_q_count[CW-1]) begin
                            n_rsp.status = fhpa_pkg::ST_BADFREE;
                        end else begin
                            m_we      = 1'b1;
                            m_waddr   = r_req.handle;
                            m_wdata   = 1'b0;
                            q_we      = 1'b1;
                            n_q_count = r_q_count + 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_idx   <= '0;
            r_q_head    <= '0;
            r_q_count   <= '0;
            r_minted    <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_idx   <= n_clr_idx;
            r_q_head    <= n_q_head;
            r_q_count   <= n_q_count;
            r_minted    <= n_minted;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rsp <= n_rsp;
        if (accept) begin
            r_req <= i_req;
        end
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    `FHPA_ASSERT_NEXT(a_accept_exec, i_clk, i_rst_n, start && !busy, r_state == S_EXEC)
    `FHPA_ASSERT_NEXT(a_exec_result, i_clk, i_rst_n, r_state == S_EXEC, o_rsp_valid)
    `FHPA_ASSERT_IMPLY(a_fail_zero, i_clk, i_rst_n,
        o_rsp_valid && o_rsp.status != fhpa_pkg::ST_OK, o_rsp.granted_handle == '0)
    `FHPA_ASSERT_IMPLY(a_queue_minted, i_clk, i_rst_n, 1'b1,
        r_q_count <= r_minted && r_minted <= POOL_LIMIT)

endmodule

@@ tb/tb_fifo_handle_pool_allocator_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fifo_handle_pool_allocator_core
// drives allocate, try-allocate, free and reserved-opcode requests into the handle pool,
// tracks the pool in a local shadow copy and checks every result against it
// ----------------------------------------------------------------------------
module tb_fifo_handle_pool_allocator_core;

    localparam int HANDLE_W     = fhpa_pkg::HANDLE_W;
    localparam int HANDLE_SPACE = fhpa_pkg::HANDLE_SPACE;
    localparam int COUNT_W      = fhpa_pkg::COUNT_W;
    localparam int POOL_SIZE    = 256;
    localparam int POOL_LIMIT   = (POOL_SIZE < HANDLE_SPACE) ? POOL_SIZE : HANDLE_SPACE;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam int REPORT_MAX   = 10;

    localparam logic [1:0] OP_RSVD = 2'd3;

    typedef enum int {MIX_BALANCED, MIX_ALLOC_HEAVY, MIX_FREE_HEAVY} t_mix;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic start   = 1'b0;
    logic busy;
    fhpa_pkg::t_req i_req = '0;
    logic o_rsp_valid;
    fhpa_pkg::t_rsp o_rsp;

    // shadow of the pool state
    logic [HANDLE_W-1:0] freed_fifo [HANDLE_SPACE];
    logic [HANDLE_W-1:0] fifo_head  = '0;
    logic [COUNT_W-1:0]  fifo_count = '0;
    logic                live_map [HANDLE_SPACE];
    logic [COUNT_W-1:0]  mint_count = '0;

    fhpa_pkg::t_req pending_reqs  [$];
    fhpa_pkg::t_rsp expected_rsps [$];

    int error_count = 0;
    int idle_cycles = 0;
    int gap_left    = 0;
    bit no_gaps     = 1'b0;

    fifo_handle_pool_allocator_core #(
        .POOL_SIZE(POOL_SIZE)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_req      (i_req),
        .o_rsp_valid(o_rsp_valid),
        .o_rsp      (o_rsp)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        for (int i = 0; i < HANDLE_SPACE; i++) begin
            live_map[i]   = 1'b0;
            freed_fifo[i] = '0;
        end
    end

    function automatic fhpa_pkg::t_rsp predict_grant(input fhpa_pkg::t_req r);
        fhpa_pkg::t_rsp      rsp;
        logic [HANDLE_W-1:0] tail;
        rsp.granted_handle = '0;
        rsp.status         = fhpa_pkg::ST_OK;
        case (r.opcode)
            fhpa_pkg::OP_ALLOC, fhpa_pkg::OP_TRY: begin
                if (fifo_count != 0) begin
                    rsp.granted_handle = freed_fifo[fifo_head];
                    fifo_head          = fifo_head + 1'b1;
                    fifo_count         = fifo_count - 1'b1;
                    live_map[rsp.granted_handle] = 1'b1;
                end else if (r.opcode == fhpa_pkg::OP_ALLOC && mint_count < POOL_LIMIT) begin
                    rsp.granted_handle = mint_count[HANDLE_W-1:0];
                    live_map[rsp.granted_handle] = 1'b1;
                    mint_count = mint_count + 1'b1;
                end else begin
                    rsp.status = fhpa_pkg::ST_NONE;
                end
            end
            fhpa_pkg::OP_FREE: begin
                if (!live_map[r.handle] || fifo_count >= HANDLE_SPACE) begin
                    rsp.status = fhpa_pkg::ST_BADFREE;
                end else begin
                    live_map[r.handle] = 1'b0;
                    tail = fifo_head + fifo_count[HANDLE_W-1:0];
                    freed_fifo[tail] = r.handle;
                    fifo_count = fifo_count + 1'b1;
                end
            end
            default: ;
        endcase
        return rsp;
    endfunction

    function automatic logic [HANDLE_W-1:0] pick_live_handle();
        int first;
        first = $urandom_range(0, HANDLE_SPACE - 1);
        for (int i = 0; i < HANDLE_SPACE; i++) begin
            if (live_map[(first + i) % HANDLE_SPACE]) begin
                return HANDLE_W'((first + i) % HANDLE_SPACE);
            end
        end
        return HANDLE_W'(first);
    endfunction

    // request driver
    always @(posedge i_clk) begin : drive
        logic           next_start;
        fhpa_pkg::t_req next_req;
        int             next_gap;
        if (!i_rst_n) begin
            start    <= 1'b0;
            gap_left <= 0;
        end else begin
            next_start = start;
            next_req   = i_req;
            next_gap   = gap_left;
            if (start && !busy) begin
                expected_rsps.push_back(predict_grant(i_req));
                next_start = 1'b0;
                if ($urandom_range(0, 39) == 0) begin
                    no_gaps = !no_gaps;
                end
                next_gap = no_gaps ? 0 : $urandom_range(0, 3);
            end
            if (!next_start) begin
                if (next_gap > 0) begin
                    next_gap--;
                end else if (pending_reqs.size() != 0) begin
                    next_req   = pending_reqs.pop_front();
                    next_start = 1'b1;
                end
            end
            start    <= next_start;
            i_req    <= next_req;
            gap_left <= next_gap;
        end
    end

    // result checker
    always @(posedge i_clk) begin : check
        fhpa_pkg::t_rsp want;
        if (i_rst_n && o_rsp_valid) begin
            if (expected_rsps.size() == 0) begin
                error_count++;
                if (error_count <= REPORT_MAX) begin
                    $display("unexpected result: handle %0d status %0d",
                             o_rsp.granted_handle, o_rsp.status);
                end
            end else begin
                want = expected_rsps.pop_front();
                if (o_rsp.granted_handle !== want.granted_handle ||
                    o_rsp.status !== want.status) begin
                    error_count++;
                    if (error_count <= REPORT_MAX) begin
                        $display({"mismatch: expected handle %0d status %0d,",
                                  " got handle %0d status %0d"},
                                 want.granted_handle, want.status,
                                 o_rsp.granted_handle, o_rsp.status);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_rsp_valid) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : watchdog
        while (idle_cycles < IDLE_LIMIT) @(posedge i_clk);
        $display("status: fail");
        $finish;
    end

    task automatic push_req(input logic [1:0] op, input logic [HANDLE_W-1:0] h);
        fhpa_pkg::t_req r;
        r.opcode = op;
        r.handle = h;
        @(negedge i_clk);
        while (pending_reqs.size() >= 2) @(negedge i_clk);
        pending_reqs.push_back(r);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        while (pending_reqs.size() != 0 || start || expected_rsps.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic run_mix(input t_mix mix, input int count);
        int roll;
        int alloc_pct;
        int try_pct;
        int free_pct;
        case (mix)
            MIX_ALLOC_HEAVY: begin alloc_pct = 80; try_pct = 85; free_pct = 95; end
            MIX_FREE_HEAVY:  begin alloc_pct = 15; try_pct = 35; free_pct = 90; end
            default:         begin alloc_pct = 40; try_pct = 55; free_pct = 90; end
        endcase
        for (int n = 0; n < count; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < alloc_pct) begin
                push_req(fhpa_pkg::OP_ALLOC, HANDLE_W'($urandom_range(0, 255)));
            end else if (roll < try_pct) begin
                push_req(fhpa_pkg::OP_TRY, HANDLE_W'($urandom_range(0, 255)));
            end else if (roll < free_pct) begin
                push_req(fhpa_pkg::OP_FREE, pick_live_handle());
            end else begin
                // noise: any opcode, any handle
                push_req(2'($urandom_range(0, 3)), HANDLE_W'($urandom_range(0, 255)));
            end
        end
    endtask

    initial begin : stimulus
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        push_req(fhpa_pkg::OP_TRY,   8'h00);
        push_req(fhpa_pkg::OP_FREE,  8'h00);
        push_req(fhpa_pkg::OP_FREE,  8'hFF);
        push_req(OP_RSVD,            8'hAA);
        push_req(fhpa_pkg::OP_ALLOC, 8'hFF);
        push_req(fhpa_pkg::OP_ALLOC, 8'h55);
        push_req(fhpa_pkg::OP_FREE,  8'h00);
        push_req(fhpa_pkg::OP_FREE,  8'h00);
        push_req(fhpa_pkg::OP_TRY,   8'hFF);
        push_req(fhpa_pkg::OP_FREE,  8'h01);
        push_req(fhpa_pkg::OP_FREE,  8'h00);
        push_req(fhpa_pkg::OP_ALLOC, 8'h00);
        push_req(fhpa_pkg::OP_TRY,   8'h00);
        push_req(fhpa_pkg::OP_TRY,   8'h00);
        push_req(fhpa_pkg::OP_ALLOC, 8'h00);
        push_req(OP_RSVD,            8'h55);
        push_req(fhpa_pkg::OP_FREE,  8'h02);
        push_req(fhpa_pkg::OP_FREE,  8'h03);
        push_req(fhpa_pkg::OP_ALLOC, 8'h00);
        wait_drained();

        run_mix(MIX_BALANCED, 150);
        run_mix(MIX_ALLOC_HEAVY, 400);
        wait_drained();
        run_mix(MIX_FREE_HEAVY, 250);
        run_mix(MIX_BALANCED, 150);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0 && expected_rsps.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/fhpa_pkg.sv
hw/rtl/fhpa_ram.sv
hw/rtl/fifo_handle_pool_allocator_core.sv
tb/tb_fifo_handle_pool_allocator_core.sv
